### src/avff_pkg.sv
package avff_pkg;

    localparam int VOLT_W      = 19;
    localparam int QUOT_W      = VOLT_W + 1;
    localparam int WEIGHT_W    = 16;
    localparam int ROUND_SHIFT = 16;
    localparam int M_TDATA_W   = ((2 * VOLT_W + 7) / 8) * 8;

    localparam logic [VOLT_W-1:0] REF_RESET = VOLT_W'(216269);
    localparam logic [VOLT_W-1:0] FILT_MAX  = VOLT_W'(327680);
    localparam logic [VOLT_W-1:0] VOLT_MAX  = {VOLT_W{1'b1}};

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic write;
        logic sum_step;
        logic scale;
        logic round;
        logic publish;
    } avff_cmd_t;

    typedef struct packed {
        logic div_last;
        logic sum_last;
    } avff_sts_t;

endpackage

### src/adc_volts_fir_filter_core.sv
// Channel   Direction  Word contents
// s_        in         tdata[SAMPLE_BITS-1:0] adc_sample, upper bits zero
// m_        out        tdata[18:0] raw_volts, tdata[37:19] filtered_volts
// cfg_      in         cfg_wr_data ref_voltage, written when cfg_wr_en is high
//
// One word passes through the load, prep, divide, write, sum, scale, round and output
// steps; the next word can be accepted once its result has been published.
// The division by full scale folds the high bits onto the low bits once per cycle
// until no high bits remain, and the accumulator walks the single read
// port of the sample history one tap per cycle.
// Reset clears the history valid bits and the write pointer and loads the 3.3 V
// reference. A stalled result holds the next one back; one word is accepted at a time.
module adc_volts_fir_filter_core #(
    parameter int TAPS        = 29,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // adc_sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // raw_volts, filtered_volts
    output logic [avff_pkg::M_TDATA_W-1:0]         m_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [avff_pkg::VOLT_W-1:0]            cfg_wr_data
);
    import avff_pkg::*;

    avff_cmd_t         cmd;
    avff_sts_t         sts;
    logic [VOLT_W-1:0] raw_volts;
    logic [VOLT_W-1:0] filtered_volts;

    avff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    avff_datapath #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .adc_sample     (s_tdata[SAMPLE_BITS-1:0]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .sts            (sts),
        .raw_volts      (raw_volts),
        .filtered_volts (filtered_volts)
    );

    assign m_tdata = M_TDATA_W'({filtered_volts, raw_volts});

endmodule

### src/avff_ctrl.sv
module avff_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  avff_pkg::avff_sts_t sts,
    output avff_pkg::avff_cmd_t cmd
);
    import avff_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_WRITE,
        ST_SUM,
        ST_SCALE,
        ST_ROUND,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   accept;
    logic   out_free;

    assign accept   = s_tvalid && s_tready_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && accept;
        cmd.prep     = (state_reg == ST_PREP);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.write    = (state_reg == ST_WRITE);
        cmd.sum_step = (state_reg == ST_SUM);
        cmd.scale    = (state_reg == ST_SCALE);
        cmd.round    = (state_reg == ST_ROUND);
        cmd.publish  = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (sts.div_last) begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    if (sts.sum_last) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        s_tready_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_rise_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("Result word raised outside the output state.");

    a_hold_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("Pending result word was overwritten.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (!s_tready_reg && state_reg == ST_PREP))
        else $error("Second word accepted while one is in flight.");

endmodule

### src/avff_datapath.sv
module avff_datapath #(
    parameter int TAPS        = 29,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [SAMPLE_BITS-1:0]                adc_sample,
    input  logic                                  cfg_wr_en,
    input  logic [avff_pkg::VOLT_W-1:0]           cfg_wr_data,
    input  avff_pkg::avff_cmd_t                   cmd,
    output avff_pkg::avff_sts_t                   sts,
    output logic [avff_pkg::VOLT_W-1:0]           raw_volts,
    output logic [avff_pkg::VOLT_W-1:0]           filtered_volts
);
    import avff_pkg::*;

    localparam int NUM_W  = SAMPLE_BITS + VOLT_W + 1;
    localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNTW   = $clog2(TAPS + 1);
    localparam int SUM_W  = VOLT_W + $clog2(TAPS);
    localparam int ACC_W  = SUM_W + WEIGHT_W;
    localparam int SHR_W  = ACC_W + 1 - ROUND_SHIFT;
    localparam int RAW_WEIGHT = (65536 + TAPS / 2) / TAPS;
    localparam logic [WEIGHT_W-1:0] TAP_WEIGHT =
        WEIGHT_W'((RAW_WEIGHT > 65535) ? 65535 : RAW_WEIGHT);
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam logic [NUM_W-1:0] HALF_SCALE = NUM_W'((2 ** SAMPLE_BITS - 1) / 2);

    logic [VOLT_W-1:0]      ref_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [QUOT_W-1:0]      quot_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic [AW-1:0]          wr_ptr_reg;
    logic [TAPS-1:0]        valid_reg;
    logic [VOLT_W-1:0]      hist_mem [TAPS];
    logic [VOLT_W-1:0]      rd_data_reg;
    logic                   rd_vld_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [VOLT_W-1:0]      raw_reg;
    logic [VOLT_W-1:0]      filt_reg;
    logic [VOLT_W-1:0]      raw_out_reg;
    logic [VOLT_W-1:0]      filt_out_reg;

    logic [QUOT_W-1:0]      num_hi;
    logic [SAMPLE_BITS-1:0] num_lo;
    logic                   div_done;
    logic [VOLT_W-1:0]      raw_sat;
    logic [ACC_W:0]         acc_rnd;
    logic [SHR_W-1:0]       acc_shr;
    logic [VOLT_W-1:0]      filt_next;
    logic [AW-1:0]          rd_addr;

    assign num_hi   = num_reg[NUM_W-1:SAMPLE_BITS];
    assign num_lo   = num_reg[SAMPLE_BITS-1:0];
    assign div_done = (num_hi == '0);
    assign raw_sat  = quot_reg[QUOT_W-1] ? VOLT_MAX : quot_reg[VOLT_W-1:0];
    assign acc_rnd  = {1'b0, acc_reg} + (ACC_W + 1)'(2 ** (ROUND_SHIFT - 1));
    assign acc_shr  = acc_rnd[ACC_W:ROUND_SHIFT];
    assign filt_next = (acc_shr > SHR_W'(FILT_MAX)) ? FILT_MAX : acc_shr[VOLT_W-1:0];
    assign rd_addr  = cnt_reg[AW-1:0];

    assign sts.div_last = div_done;
    assign sts.sum_last = (cnt_reg == CNTW'(TAPS));

    assign raw_volts      = raw_out_reg;
    assign filtered_volts = filt_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg    <= REF_RESET;
            valid_reg  <= '0;
            wr_ptr_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                ref_reg <= cfg_wr_data;
            end
            if (cmd.write) begin
                valid_reg[wr_ptr_reg] <= 1'b1;
                if (wr_ptr_reg == AW'(TAPS - 1)) begin
                    wr_ptr_reg <= '0;
                end else begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            hist_mem[wr_ptr_reg] <= raw_sat;
        end
        if (cmd.sum_step && (cnt_reg < CNTW'(TAPS))) begin
            rd_data_reg <= hist_mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            num_reg <= NUM_W'(adc_sample) * NUM_W'(ref_reg) + HALF_SCALE;
        end else if (cmd.div_step && !div_done) begin
            num_reg <= NUM_W'(num_hi) + NUM_W'(num_lo);
        end
        if (cmd.write) begin
            cnt_reg <= '0;
        end else if (cmd.sum_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.prep) begin
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            if (!div_done) begin
                quot_reg <= quot_reg + num_hi;
            end else if (num_lo == FULL_SCALE) begin
                quot_reg <= quot_reg + 1'b1;
            end
        end
        if (cmd.write) begin
            raw_reg <= raw_sat;
            sum_reg <= '0;
        end else if (cmd.sum_step && (cnt_reg != '0) && rd_vld_reg) begin
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
        end
        if (cmd.scale) begin
            acc_reg <= ACC_W'(sum_reg) * ACC_W'(TAP_WEIGHT);
        end
        if (cmd.round) begin
            filt_reg <= filt_next;
        end
        if (cmd.publish) begin
            raw_out_reg  <= raw_reg;
            filt_out_reg <= filt_reg;
        end
    end

    a_div_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> (num_hi == '0))
        else $error("Scaling reduction left high bits behind.");

    a_quot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> (quot_reg <= QUOT_W'(VOLT_MAX) + QUOT_W'(2)))
        else $error("Scaled quotient out of range.");

    a_filt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> (filt_out_reg <= FILT_MAX))
        else $error("Filter output above its limit.");

endmodule
